// ===== rtl/bmpp_pkg.sv =====
// shared types and constants for the bmp row pixel packer
package bmpp_pkg;

  localparam int unsigned MAX_WIDTH_DEFAULT = 4096;

  localparam int unsigned PIX_W      = 24;
  localparam int unsigned DEPTH_W    = 3;
  localparam int unsigned ROW_W      = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DEPTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 1'b1;

  // depth codes as written to the depth register
  localparam logic [DEPTH_W-1:0] DEPTH_CODE_1  = 3'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_CODE_2  = 3'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_CODE_4  = 3'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_CODE_8  = 3'd3;
  localparam logic [DEPTH_W-1:0] DEPTH_CODE_24 = 3'd4;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_CODE_8;
  localparam logic [ROW_W-1:0]   ROW_RESET   = 13'd1;

  typedef enum logic [2:0] {
    BPP_1,
    BPP_2,
    BPP_4,
    BPP_8,
    BPP_24
  } bpp_t;

endpackage

// ===== rtl/bmpp_pix_if.sv =====
// pixel input channel
interface bmpp_pix_if;
  logic                         valid;
  logic                         ready;
  logic [bmpp_pkg::PIX_W-1:0]   pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

// ===== rtl/bmpp_byte_if.sv =====
// packed byte output channel
interface bmpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       row_end;

  modport source (output valid, output out_byte, output run_end, output row_end, input ready);
  modport sink   (input valid, input out_byte, input run_end, input row_end, output ready);
endinterface

// ===== rtl/bmpp_cfg_if.sv =====
// configuration write channel
interface bmpp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bmpp_pkg::CFG_IDX_W-1:0]    index;
  logic [bmpp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bmp_row_pixel_packer.sv =====
// top level: packs raster pixels into padded bmp row bytes
//
// usage
//   pix_in   : one pixel per request, 24-bit value (rgb or palette index)
//   byte_out : one packed row byte per request, with run_end on the last
//              byte a pixel causes and row_end on the last byte of a row
//   cfg      : register writes (0 = pixel depth, 1 = row width), always ready;
//              any write restarts the row, write only while the block is idle
// path
//   the bytes of a pixel pass through the burst register, then the output register
// throughput
//   one byte per cycle from a single burst register while byte_out.ready is high;
//   a pixel occupies it until all the bytes it causes have gone out: 3 at 24 bits,
//   1 at 8 bits, 0 or 1 for sub-byte pixels, plus up to 3 pad bytes at the end of a row
//   a pixel causing no byte never occupies the burst register
// reset
//   depth 8 bits, row width 1, row state cleared, both channels empty
// stall
//   the output register holds while byte_out.ready is low; the burst and
//   then pix_in.ready back up behind it, no byte is dropped
module bmp_row_pixel_packer #(
  parameter int unsigned MAX_WIDTH = bmpp_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  bmpp_pix_if.sink          pix_in,
  bmpp_byte_if.source       byte_out,
  bmpp_cfg_if.sink          cfg
);

  // column counter only ever holds 0 .. MAX_WIDTH-1
  localparam int unsigned CNT_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  // compare width covers both the row width register and MAX_WIDTH
  localparam int unsigned MAXW_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W  =
    ((MAXW_W > bmpp_pkg::ROW_W) ? MAXW_W : bmpp_pkg::ROW_W) + 1;

  // configuration
  logic [bmpp_pkg::DEPTH_W-1:0] pixel_depth;
  logic [bmpp_pkg::ROW_W-1:0]   row_width;

  // row state
  logic [7:0]       partial_byte;
  logic [2:0]       pixels_in_byte;
  logic [CNT_W-1:0] column_count;
  logic [1:0]       row_byte_phase;

  // burst register: bytes of one pixel waiting to go out
  logic             burst_valid;
  logic [7:0]       burst_data [3];
  logic [1:0]       burst_nd;
  logic [2:0]       burst_n;
  logic [2:0]       burst_idx;
  logic             burst_row;

  // output register
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_run;
  logic             out_row;

  // combinational per-pixel work
  bmpp_pkg::bpp_t   bpp;
  logic [2:0]       last_slot;
  logic [2:0]       pib_eff;
  logic [7:0]       vsh;
  logic [7:0]       pb_new;
  logic             full;
  logic [2:0]       pib_after;
  logic [7:0]       pb_after;
  logic [CMP_W-1:0] width_eff;
  logic [CMP_W-1:0] col_inc;
  logic             row_done;
  logic [CNT_W-1:0] col_next;
  logic [1:0]       nd;
  logic [7:0]       data_next [3];
  logic [1:0]       phase_d;
  logic [1:0]       npad;
  logic [2:0]       n_total;
  logic [1:0]       phase_next;

  logic             in_acc;
  logic             cfg_acc;
  logic             out_free;
  logic             burst_move;
  logic             burst_last;
  logic [7:0]       burst_byte;

  // handshakes
  assign out_free   = !out_valid || byte_out.ready;
  assign burst_move = burst_valid && out_free;
  assign burst_last = (burst_idx == (burst_n - 3'd1));
  assign pix_in.ready = !burst_valid || (burst_move && burst_last);
  assign in_acc     = pix_in.valid && pix_in.ready;
  assign cfg.ready  = 1'b1;
  assign cfg_acc    = cfg.valid;

  assign byte_out.valid    = out_valid;
  assign byte_out.out_byte = out_byte;
  assign byte_out.run_end  = out_run;
  assign byte_out.row_end  = out_row;

  // depth decode, undefined codes act as 8 bits
  always_comb begin
    case (pixel_depth)
      bmpp_pkg::DEPTH_CODE_1:  bpp = bmpp_pkg::BPP_1;
      bmpp_pkg::DEPTH_CODE_2:  bpp = bmpp_pkg::BPP_2;
      bmpp_pkg::DEPTH_CODE_4:  bpp = bmpp_pkg::BPP_4;
      bmpp_pkg::DEPTH_CODE_24: bpp = bmpp_pkg::BPP_24;
      default:                 bpp = bmpp_pkg::BPP_8;
    endcase
  end

  // sub-byte packing, high bits first
  always_comb begin
    case (bpp)
      bmpp_pkg::BPP_1: last_slot = 3'd7;
      bmpp_pkg::BPP_2: last_slot = 3'd3;
      default:         last_slot = 3'd1;
    endcase
    pib_eff = (pixels_in_byte > last_slot) ? 3'd0 : pixels_in_byte;
    case (bpp)
      bmpp_pkg::BPP_1: vsh = (pix_in.pixel_value != '0) ? (8'h80 >> pib_eff) : 8'h00;
      bmpp_pkg::BPP_2: vsh = {pix_in.pixel_value[1:0], 6'b0} >> {pib_eff[1:0], 1'b0};
      default:         vsh = {pix_in.pixel_value[3:0], 4'b0} >> {pib_eff[0], 2'b0};
    endcase
    pb_new    = partial_byte | vsh;
    full      = (pib_eff == last_slot);
    pib_after = full ? 3'd0 : (pib_eff + 3'd1);
    pb_after  = full ? 8'h00 : pb_new;
  end

  // row position, width clamped to 1 .. MAX_WIDTH
  always_comb begin
    if (row_width == '0) begin
      width_eff = CMP_W'(1);
    end else if (CMP_W'(row_width) > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = CMP_W'(row_width);
    end
    col_inc  = CMP_W'(column_count) + CMP_W'(1);
    row_done = (col_inc >= width_eff);
    col_next = row_done ? '0 : CNT_W'(col_inc);
  end

  // bytes this pixel causes, then row padding
  always_comb begin
    data_next[0] = pb_new;
    data_next[1] = 8'h00;
    data_next[2] = 8'h00;
    nd           = 2'd0;
    case (bpp)
      bmpp_pkg::BPP_24: begin
        data_next[0] = pix_in.pixel_value[7:0];
        data_next[1] = pix_in.pixel_value[15:8];
        data_next[2] = pix_in.pixel_value[23:16];
        nd           = 2'd3;
      end
      bmpp_pkg::BPP_8: begin
        data_next[0] = pix_in.pixel_value[7:0];
        nd           = 2'd1;
      end
      default: begin
        // a full byte or a flushed partial byte at row end
        nd = (full || (row_done && (pib_after != 3'd0))) ? 2'd1 : 2'd0;
      end
    endcase
    phase_d    = row_byte_phase + nd;
    npad       = row_done ? (2'd0 - phase_d) : 2'd0;
    n_total    = {1'b0, nd} + {1'b0, npad};
    phase_next = row_done ? 2'd0 : phase_d;
  end

  assign burst_byte = ({1'b0, burst_nd} > burst_idx) ? burst_data[burst_idx[1:0]] : 8'h00;

  // configuration and row state
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_depth    <= bmpp_pkg::DEPTH_RESET;
      row_width      <= bmpp_pkg::ROW_RESET;
      partial_byte   <= 8'h00;
      pixels_in_byte <= 3'd0;
      column_count   <= '0;
      row_byte_phase <= 2'd0;
    end else if (cfg_acc) begin
      if (cfg.index == bmpp_pkg::REG_PIXEL_DEPTH) begin
        pixel_depth <= cfg.data[bmpp_pkg::DEPTH_W-1:0];
      end
      if (cfg.index == bmpp_pkg::REG_ROW_WIDTH) begin
        row_width <= cfg.data[bmpp_pkg::ROW_W-1:0];
      end
      partial_byte   <= 8'h00;
      pixels_in_byte <= 3'd0;
      column_count   <= '0;
      row_byte_phase <= 2'd0;
    end else if (in_acc) begin
      if ((bpp == bmpp_pkg::BPP_8) || (bpp == bmpp_pkg::BPP_24) || row_done) begin
        partial_byte   <= 8'h00;
        pixels_in_byte <= 3'd0;
      end else begin
        partial_byte   <= pb_after;
        pixels_in_byte <= pib_after;
      end
      column_count   <= col_next;
      row_byte_phase <= phase_next;
    end
  end

  // burst register, a new pixel only lands once the old burst is leaving
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
      burst_idx   <= 3'd0;
    end else if (in_acc && (n_total != 3'd0)) begin
      burst_valid <= 1'b1;
      burst_idx   <= 3'd0;
    end else if (burst_move) begin
      burst_idx <= burst_idx + 3'd1;
      if (burst_last) begin
        burst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      burst_data <= data_next;
      burst_nd   <= nd;
      burst_n    <= n_total;
      burst_row  <= row_done;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= burst_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_move) begin
      out_byte <= burst_byte;
      out_run  <= burst_last;
      out_row  <= burst_last && burst_row;
    end
  end

  // checks
  a_burst_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    burst_valid |-> ((burst_n != 3'd0) && (burst_idx < burst_n)))
    else $error("burst index beyond burst length");

  a_row_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_row) |-> out_run)
    else $error("row end byte not marked as last of its pixel");

  a_accept_only_when_drained: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> (!burst_valid || (burst_move && burst_last)))
    else $error("pixel taken while burst still busy");

  a_row_padded: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !cfg_acc && row_done) |=> (row_byte_phase == 2'd0))
    else $error("row not padded to four bytes");

endmodule

// ===== sim/testbench.sv =====
// testbench for the bmp row pixel packer: random pixel rows checked against a byte predictor
`timescale 1ns / 1ps

module testbench;

  // one packed row byte as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       row_end;
  } row_byte_t;

  localparam int unsigned MAX_W      = bmpp_pkg::MAX_WIDTH_DEFAULT;
  localparam int unsigned CYCLE_CAP  = 600000;
  localparam int unsigned RAND_ITEMS = 250;

  // byte predictor and store of the bytes still owed by the block
  class row_scoreboard;
    logic [bmpp_pkg::DEPTH_W-1:0] depth_code;
    logic [bmpp_pkg::ROW_W-1:0]   width_reg;
    logic [7:0]         partial;
    int unsigned        fill;
    int unsigned        column;
    logic [1:0]         phase;
    row_byte_t          owed_q[$];
    row_byte_t          burst_q[$];
    int                 errors;
    int                 bytes_seen;

    function new();
      depth_code = bmpp_pkg::DEPTH_RESET;
      width_reg  = bmpp_pkg::ROW_RESET;
      errors     = 0;
      bytes_seen = 0;
      clear_row();
    endfunction

    function void clear_row();
      partial = 8'h00;
      fill    = 0;
      column  = 0;
      phase   = 2'd0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void write_reg(logic [bmpp_pkg::CFG_IDX_W-1:0] idx,
                            logic [bmpp_pkg::CFG_DATA_W-1:0] data);
      if (idx == bmpp_pkg::REG_PIXEL_DEPTH) depth_code = data[bmpp_pkg::DEPTH_W-1:0];
      else width_reg = data[bmpp_pkg::ROW_W-1:0];
      clear_row();
    endfunction

    function void emit(logic [7:0] b);
      row_byte_t rb;
      rb.data    = b;
      rb.run_end = 1'b0;
      rb.row_end = 1'b0;
      burst_q.push_back(rb);
      phase = phase + 2'd1;
    endfunction

    // bytes caused by one accepted pixel
    function void note_pixel(logic [bmpp_pkg::PIX_W-1:0] pix);
      int unsigned bits;
      int unsigned per_byte;
      int unsigned eff_width;
      int unsigned shift;
      logic [7:0]  v;
      burst_q.delete();
      eff_width = width_reg;
      if (eff_width < 1) eff_width = 1;
      if (eff_width > MAX_W) eff_width = MAX_W;
      case (depth_code)
        bmpp_pkg::DEPTH_CODE_1:  bits = 1;
        bmpp_pkg::DEPTH_CODE_2:  bits = 2;
        bmpp_pkg::DEPTH_CODE_4:  bits = 4;
        bmpp_pkg::DEPTH_CODE_24: bits = 24;
        default:                 bits = 8;
      endcase
      if (bits == 24) begin
        emit(pix[7:0]);
        emit(pix[15:8]);
        emit(pix[23:16]);
      end else if (bits == 8) begin
        emit(pix[7:0]);
      end else begin
        per_byte = 8 / bits;
        if (bits == 1) v = (pix != '0) ? 8'd1 : 8'd0;
        else v = pix[7:0] & ((8'd1 << bits) - 8'd1);
        shift = 8 - bits * (fill + 1);
        partial = partial | (v << shift);
        fill++;
        if (fill == per_byte) begin
          emit(partial);
          partial = 8'h00;
          fill = 0;
        end
      end
      column++;
      if (column >= eff_width) begin
        if (fill != 0) begin
          emit(partial);
          partial = 8'h00;
          fill = 0;
        end
        while (phase != 2'd0) emit(8'h00);
        column = 0;
        if (burst_q.size() > 0) burst_q[burst_q.size()-1].row_end = 1'b1;
      end
      if (burst_q.size() > 0) burst_q[burst_q.size()-1].run_end = 1'b1;
      foreach (burst_q[i]) owed_q.push_back(burst_q[i]);
    endfunction

    function void check_byte(logic [7:0] b, logic run_e, logic row_e);
      row_byte_t want;
      bytes_seen++;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected byte %02h run_end %0b row_end %0b", $time, b, run_e, row_e);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (b !== want.data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.data, b);
        errors++;
      end
      if (run_e !== want.run_end) begin
        $display("%0t: run_end expected %0b actual %0b", $time, want.run_end, run_e);
        errors++;
      end
      if (row_e !== want.row_end) begin
        $display("%0t: row_end expected %0b actual %0b", $time, want.row_end, row_e);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic quiet;              // no idling on either side while set
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned reg_writes;
  int unsigned phases_run;

  row_scoreboard sb = new();

  bmpp_pix_if  pix();
  bmpp_byte_if bout();
  bmpp_cfg_if  cfg();

  bmp_row_pixel_packer u_dut (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix),
    .byte_out (bout),
    .cfg      (cfg)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver holds ready low about 29 percent of the time
  always @(posedge clk) begin
    bout.ready <= quiet || ($urandom_range(0, 99) >= 29);
  end

  // every byte request is checked against the oldest owed byte
  always @(posedge clk) begin
    if (!rst && bout.valid && bout.ready)
      sb.check_byte(bout.out_byte, bout.run_end, bout.row_end);
  end

  // run limit, far above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout with %0d bytes still owed", $time, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // random pixel value, extremes weighted in
  function automatic logic [bmpp_pkg::PIX_W-1:0] rand_pixel();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return r[bmpp_pkg::PIX_W-1:0];
    endcase
  endfunction

  // one pixel request; valid stays high across back-to-back requests
  task automatic send_pixel(input logic [bmpp_pkg::PIX_W-1:0] v);
    if (!quiet && $urandom_range(0, 99) < 29) begin
      pix.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 29) @(posedge clk);
    end
    pix.valid       <= 1'b1;
    pix.pixel_value <= v;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    sb.note_pixel(v);
    items_sent++;
  endtask

  // wait until every owed byte is out, then let the pipe settle
  task automatic drain(input int unsigned settle);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input logic [bmpp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bmpp_pkg::CFG_DATA_W-1:0] data);
    pix.valid <= 1'b0;
    drain(8);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.write_reg(idx, data);
    reg_writes++;
    cfg.valid <= 1'b0;
  endtask

  // depth write with random junk above the three code bits
  task automatic set_depth(input logic [bmpp_pkg::DEPTH_W-1:0] code);
    logic [bmpp_pkg::CFG_DATA_W-1:0] d;
    d = bmpp_pkg::CFG_DATA_W'($urandom_range(0, 1023)) << bmpp_pkg::DEPTH_W;
    d[bmpp_pkg::DEPTH_W-1:0] = code;
    write_reg(bmpp_pkg::REG_PIXEL_DEPTH, d);
  endtask

  task automatic send_row(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_pixel(rand_pixel());
  endtask

  initial begin
    int unsigned w;
    int unsigned eff;
    int unsigned rows;
    int unsigned r;
    logic [bmpp_pkg::DEPTH_W-1:0] code;
    // all block inputs known from time zero
    rst             = 1'b1;
    quiet           = 1'b0;
    pix.valid       = 1'b0;
    pix.pixel_value = '0;
    cfg.valid       = 1'b0;
    cfg.index       = '0;
    cfg.data        = '0;
    items_sent = 0;
    reg_writes = 0;
    phases_run = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: 8 bits, width 1, each pixel padded to four bytes
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);

    // 24 bits, width 3: last pixel gives three bytes plus three pad bytes
    set_depth(bmpp_pkg::DEPTH_CODE_24);
    write_reg(bmpp_pkg::REG_ROW_WIDTH, 13'd3);
    send_pixel(24'h123456);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hA5C30F);

    // 1 bit, width 9: nonzero values set a bit, ninth pixel flushes a partial byte
    set_depth(bmpp_pkg::DEPTH_CODE_1);
    write_reg(bmpp_pkg::REG_ROW_WIDTH, 13'd9);
    send_pixel(24'h000001);
    send_pixel(24'h000000);
    send_pixel(24'h800000);
    send_pixel(24'h000000);
    send_pixel(24'h000100);
    send_pixel(24'h000000);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000002);

    // 2 bits, width 3: low bits only, flush with zero low bits
    set_depth(bmpp_pkg::DEPTH_CODE_2);
    write_reg(bmpp_pkg::REG_ROW_WIDTH, 13'd3);
    send_pixel(24'h000003);
    send_pixel(24'hFFFFF1);
    send_pixel(24'hFFFFFE);

    // 4 bits, width 2: one full byte
    set_depth(bmpp_pkg::DEPTH_CODE_4);
    write_reg(bmpp_pkg::REG_ROW_WIDTH, 13'd2);
    send_pixel(24'h00000F);
    send_pixel(24'hFFFFA5);

    // undefined depth code acts as 8 bits, width zero acts as 1
    set_depth(3'd5);
    write_reg(bmpp_pkg::REG_ROW_WIDTH, 13'd0);
    send_pixel(24'h5A5AAB);

    // random phases: whole rows with random content, some broken rows
    while (items_sent < RAND_ITEMS - 20) begin
      quiet = (phases_run >= 2 && phases_run < 5);
      code = ($urandom_range(0, 9) < 8) ? bmpp_pkg::DEPTH_W'($urandom_range(0, 4))
                                        : bmpp_pkg::DEPTH_W'($urandom_range(5, 7));
      r = $urandom_range(0, 9);
      if (r < 6) w = $urandom_range(1, 12);
      else if (r < 9) w = $urandom_range(13, 40);
      else w = 0;
      eff = (w == 0) ? 1 : w;
      if ($urandom_range(0, 1) == 1) begin
        set_depth(code);
        write_reg(bmpp_pkg::REG_ROW_WIDTH, bmpp_pkg::CFG_DATA_W'(w));
      end else begin
        write_reg(bmpp_pkg::REG_ROW_WIDTH, bmpp_pkg::CFG_DATA_W'(w));
        set_depth(code);
      end
      rows = $urandom_range(1, 3);
      for (int unsigned k = 0; k < rows; k++) send_row(eff);
      // a broken row, cut short by the next register write
      if (eff > 1 && $urandom_range(0, 9) < 3) send_row($urandom_range(1, eff - 1));
      phases_run++;
    end
    quiet = 1'b0;

    // width above the limit clamps, so a short row never ends
    set_depth(bmpp_pkg::DEPTH_CODE_2);
    write_reg(bmpp_pkg::REG_ROW_WIDTH, 13'd8191);
    send_row(12);
    phases_run++;

    pix.valid <= 1'b0;
    drain(32);

    $display("covered %0d pixels in %0d phases, %0d register writes, %0d bytes checked",
             items_sent, phases_run, reg_writes, sb.bytes_seen);
    $display("depths 1, 2, 4, 8, 24 and undefined codes, widths 0 to 8191, %0d mismatches",
             sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bmpp_pkg.sv
rtl/bmpp_pix_if.sv
rtl/bmpp_byte_if.sv
rtl/bmpp_cfg_if.sv
rtl/bmp_row_pixel_packer.sv
sim/testbench.sv
